[src/dmp_pkg.sv]
package dmp_pkg;

	// Parser states; codes above the last member never occur in the register
	typedef enum logic [3:0] {
		PS_TEXT, PS_ESC, PS_UNDER, PS_EXPAND, PS_PROP, PS_SCRIPT, PS_MASTER,
		PS_FEED, PS_SPACE_A, PS_SPACE_3, PS_GN1, PS_GN2, PS_GDATA
	} pstate_t;

	// Byte classes seen in the text state
	typedef enum logic [2:0] {
		CL_PRINT, CL_ESC, CL_SI, CL_DC2, CL_FF, CL_CR, CL_LF, CL_EOL
	} bclass_t;

	typedef enum logic [2:0] {
		EV_CHAR, EV_FLUSH, EV_CR, EV_LF, EV_FF, EV_VF, EV_GFX
	} evkind_t;

	typedef enum logic [1:0] {GM_Z, GM_K, GM_LY} gmode_t;

	typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_EMIT} bstate_t;

	typedef enum logic {CFG_TOP_MARGIN, CFG_PAGE_LENGTH} cfg_idx_t;

	// Queue entry from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
		bclass_t    cls;
	} qitem_t;

	// Event record held by the back end until delivered
	typedef struct packed {
		evkind_t    kind;
		logic [6:0] ch;
		logic [7:0] pins;
		logic [2:0] dw;
		logic [6:0] style;
	} event_t;

	localparam logic [7:0] BYTE_ESC = 8'd27;
	localparam logic [7:0] BYTE_SI  = 8'd15;
	localparam logic [7:0] BYTE_DC2 = 8'd18;
	localparam logic [7:0] BYTE_FF  = 8'd12;
	localparam logic [7:0] BYTE_CR  = 8'd13;
	localparam logic [7:0] BYTE_LF  = 8'd10;
	localparam logic [7:0] BYTE_EOL = 8'd155;

	localparam int F_BOLD   = 0;
	localparam int F_UNDER  = 1;
	localparam int F_ITALIC = 2;
	localparam int F_COND   = 3;
	localparam int F_EXPAND = 4;
	localparam int F_ELITE  = 5;
	localparam int F_PROP   = 6;

	localparam logic [7:0] COLS_COND  = 8'd132;
	localparam logic [7:0] COLS_ELITE = 8'd96;
	localparam logic [7:0] COLS_PICA  = 8'd80;

	localparam logic [9:0]  LS_RESET = 10'd36;
	localparam logic [9:0]  TM_RESET = 10'd108;
	localparam logic [15:0] PL_RESET = 16'd2376;

	localparam int MAX_EVENTS = 3;

endpackage

[src/dmp_if.sv]
interface dmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source(output valid, data_byte, frame_end, input ready);
	modport sink(input valid, data_byte, frame_end, output ready);
endinterface

interface dmp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_kind;
	logic [6:0]  char_code;
	logic [7:0]  pin_bits;
	logic [2:0]  dot_width;
	logic [23:0] cursor_y;
	logic [6:0]  style_flags;
	logic [1:0]  script_mode;
	logic [9:0]  line_height_out;
	logic        last_event;

	modport source(output valid, event_kind, char_code, pin_bits, dot_width, cursor_y,
		style_flags, script_mode, line_height_out, last_event, input ready);
	modport sink(input valid, event_kind, char_code, pin_bits, dot_width, cursor_y,
		style_flags, script_mode, line_height_out, last_event, output ready);
endinterface

[src/dmp_front.sv]
module dmp_front (
	input  logic             clk,
	input  logic             arst_n,
	dmp_in_if.sink           in_ch,
	output dmp_pkg::qitem_t  head,
	output logic             head_valid,
	input  logic             pop
);

	dmp_pkg::qitem_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	dmp_pkg::qitem_t item;

	// Classify the incoming byte
	always_comb begin
		item.data_byte = in_ch.data_byte;
		item.frame_end = in_ch.frame_end;
		case (in_ch.data_byte)
			dmp_pkg::BYTE_ESC: item.cls = dmp_pkg::CL_ESC;
			dmp_pkg::BYTE_SI:  item.cls = dmp_pkg::CL_SI;
			dmp_pkg::BYTE_DC2: item.cls = dmp_pkg::CL_DC2;
			dmp_pkg::BYTE_FF:  item.cls = dmp_pkg::CL_FF;
			dmp_pkg::BYTE_CR:  item.cls = dmp_pkg::CL_CR;
			dmp_pkg::BYTE_LF:  item.cls = dmp_pkg::CL_LF;
			dmp_pkg::BYTE_EOL: item.cls = dmp_pkg::CL_EOL;
			default:           item.cls = dmp_pkg::CL_PRINT;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign head        = mem_q[rd_ptr_q];
	assign head_valid  = (cnt_q != 2'd0);

	// Store items in arrival order
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[src/dmp_back.sv]
module dmp_back #(
	parameter int CB = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [9:0]       top_margin,
	input  logic [15:0]      page_length,
	input  dmp_pkg::qitem_t  head,
	input  logic             head_valid,
	output logic             pop,
	dmp_out_if.source        out_ch
);

	localparam int          CW   = $clog2(CB + 1);
	localparam logic [CB-1:0] VMAX = '1;
	localparam logic [CB-1:0] YMAX = CB'(24'hFFFFFF);

	dmp_pkg::bstate_t st_q, st_d;
	dmp_pkg::pstate_t pst_q, pst_d;
	dmp_pkg::gmode_t  gmode_q, gmode_d;
	logic             skip_q, skip_d;
	logic [6:0]       style_q, style_d;
	logic [1:0]       script_q, script_d;
	logic [9:0]       ls_q, ls_d;
	logic [CB-1:0]    vy_q, vy_d, vy_old_q;
	logic [7:0]       cols_q, cols_d;
	logic [15:0]      grem_q, grem_d;
	dmp_pkg::event_t  ev_q [dmp_pkg::MAX_EVENTS];
	dmp_pkg::event_t  ev_d [dmp_pkg::MAX_EVENTS];
	logic [1:0]       n_q, n_d, idx_q;
	logic             ff_d;
	logic             load;
	logic             last_ev;

	logic [16:0]      rem_q, rem_nx;
	logic [CB-1:0]    dsh_q;
	logic [CW-1:0]    dcnt_q;
	logic [CB+1:0]    ffb_q, ff_t;
	logic [15:0]      pdiv;

	logic [CB:0]      sum_lf, sum_vf;
	logic [CB-1:0]    vy_lf, vy_vf;
	logic [7:0]       b;
	logic [6:0]       c7;
	logic             on;
	logic [7:0]       limit;

	logic             out_v_q;
	dmp_pkg::event_t  cur;
	logic [CB-1:0]    y_sel;
	logic [CB+23:0]   y_wide;

	function automatic dmp_pkg::event_t mk_ev(dmp_pkg::evkind_t k, logic [6:0] ch,
			logic [7:0] pins, logic [2:0] dw, logic [6:0] st);
		dmp_pkg::event_t e;
		e.kind  = k;
		e.ch    = ch;
		e.pins  = pins;
		e.dw    = dw;
		e.style = st;
		return e;
	endfunction

	assign b      = head.data_byte;
	assign c7     = b[6:0];
	assign on     = (b == "1") || (b == 8'd1);
	assign sum_lf = {1'b0, vy_q} + (CB+1)'(ls_q);
	assign vy_lf  = sum_lf[CB] ? VMAX : sum_lf[CB-1:0];
	assign sum_vf = {1'b0, vy_q} + (CB+1)'(b);
	assign vy_vf  = sum_vf[CB] ? VMAX : sum_vf[CB-1:0];
	assign pdiv   = (page_length == 16'd0) ? 16'd1 : page_length;

	// Decode the head item into new state and an event list
	always_comb begin
		pst_d    = pst_q;
		gmode_d  = gmode_q;
		skip_d   = skip_q;
		style_d  = style_q;
		script_d = script_q;
		ls_d     = ls_q;
		vy_d     = vy_q;
		cols_d   = cols_q;
		grem_d   = grem_q;
		ff_d     = 1'b0;
		n_d      = 2'd0;
		limit    = dmp_pkg::COLS_PICA;
		for (int i = 0; i < dmp_pkg::MAX_EVENTS; i++) begin
			ev_d[i] = '0;
		end
		if (skip_q) begin
			if (head.frame_end) begin
				skip_d = 1'b0;
			end
		end else begin
			case (pst_q)
				dmp_pkg::PS_ESC: begin
					pst_d = dmp_pkg::PS_TEXT;
					case (b)
						"K": begin gmode_d = dmp_pkg::GM_K; pst_d = dmp_pkg::PS_GN1; end
						"L", "Y": begin gmode_d = dmp_pkg::GM_LY; pst_d = dmp_pkg::PS_GN1; end
						"Z": begin gmode_d = dmp_pkg::GM_Z; pst_d = dmp_pkg::PS_GN1; end
						"A": pst_d = dmp_pkg::PS_SPACE_A;
						"3": pst_d = dmp_pkg::PS_SPACE_3;
						"J": pst_d = dmp_pkg::PS_FEED;
						"E", "G": style_d[dmp_pkg::F_BOLD] = 1'b1;
						"F", "H": style_d[dmp_pkg::F_BOLD] = 1'b0;
						"4": style_d[dmp_pkg::F_ITALIC] = 1'b1;
						"5": style_d[dmp_pkg::F_ITALIC] = 1'b0;
						"-": pst_d = dmp_pkg::PS_UNDER;
						"W": pst_d = dmp_pkg::PS_EXPAND;
						"M": style_d[dmp_pkg::F_ELITE] = 1'b1;
						"P": style_d[dmp_pkg::F_ELITE] = 1'b0;
						"p": pst_d = dmp_pkg::PS_PROP;
						"S": pst_d = dmp_pkg::PS_SCRIPT;
						"T": script_d = 2'd0;
						"!": pst_d = dmp_pkg::PS_MASTER;
						"0": ls_d = 10'd27;
						"1": ls_d = 10'd21;
						"2": ls_d = dmp_pkg::LS_RESET;
						default: ;
					endcase
				end
				dmp_pkg::PS_UNDER: begin
					style_d[dmp_pkg::F_UNDER] = on;
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_EXPAND: begin
					style_d[dmp_pkg::F_EXPAND] = on;
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_PROP: begin
					style_d[dmp_pkg::F_PROP] = on;
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_SCRIPT: begin
					script_d = (b == "0" || b == 8'd0) ? 2'd1 : 2'd2;
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_MASTER: begin
					style_d[dmp_pkg::F_BOLD]   = b[3] || b[4];
					style_d[dmp_pkg::F_UNDER]  = b[7];
					style_d[dmp_pkg::F_ITALIC] = b[6];
					style_d[dmp_pkg::F_COND]   = b[2];
					style_d[dmp_pkg::F_EXPAND] = b[5];
					style_d[dmp_pkg::F_ELITE]  = b[0];
					style_d[dmp_pkg::F_PROP]   = b[1];
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_FEED: begin
					vy_d = vy_vf;
					ev_d[0] = mk_ev(dmp_pkg::EV_VF, 7'd0, 8'd0, 3'd1, style_q);
					n_d = 2'd1;
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_SPACE_A: begin
					ls_d = {2'b00, b} + {1'b0, b, 1'b0};
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_SPACE_3: begin
					ls_d = {2'b00, b};
					pst_d = dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_GN1: begin
					grem_d = {8'd0, b};
					pst_d = dmp_pkg::PS_GN2;
				end
				dmp_pkg::PS_GN2: begin
					grem_d = grem_q + {b, 8'd0};
					pst_d = (grem_d != 16'd0) ? dmp_pkg::PS_GDATA : dmp_pkg::PS_TEXT;
				end
				dmp_pkg::PS_GDATA: begin
					ev_d[0] = mk_ev(dmp_pkg::EV_GFX, 7'd0, b,
						(gmode_q == dmp_pkg::GM_K) ? 3'd4 :
						((gmode_q == dmp_pkg::GM_LY) ? 3'd2 : 3'd1), style_q);
					n_d = 2'd1;
					grem_d = (grem_q != 16'd0) ? grem_q - 16'd1 : 16'd0;
					if (grem_d == 16'd0) begin
						pst_d = dmp_pkg::PS_TEXT;
					end
				end
				default: begin
					pst_d = dmp_pkg::PS_TEXT;
					if (head.cls != dmp_pkg::CL_PRINT) begin
						// Control byte: flush a pending line first
						if (cols_q != 8'd0) begin
							ev_d[n_d] = mk_ev(dmp_pkg::EV_FLUSH, 7'd0, 8'd0, 3'd1, style_q);
							n_d = n_d + 2'd1;
						end
						cols_d = 8'd0;
						case (head.cls)
							dmp_pkg::CL_ESC: pst_d = dmp_pkg::PS_ESC;
							dmp_pkg::CL_SI:  style_d[dmp_pkg::F_COND] = 1'b1;
							dmp_pkg::CL_DC2: style_d[dmp_pkg::F_COND] = 1'b0;
							dmp_pkg::CL_FF: begin
								ff_d = 1'b1;
								ev_d[n_d] = mk_ev(dmp_pkg::EV_FF, 7'd0, 8'd0, 3'd1, style_q);
								n_d = n_d + 2'd1;
							end
							dmp_pkg::CL_CR: begin
								ev_d[n_d] = mk_ev(dmp_pkg::EV_CR, 7'd0, 8'd0, 3'd1, style_q);
								n_d = n_d + 2'd1;
							end
							dmp_pkg::CL_LF, dmp_pkg::CL_EOL: begin
								vy_d = vy_lf;
								ev_d[n_d] = mk_ev(dmp_pkg::EV_LF, 7'd0, 8'd0, 3'd1, style_q);
								n_d = n_d + 2'd1;
								if (head.cls == dmp_pkg::CL_EOL) begin
									skip_d = !head.frame_end;
								end
							end
							default: ;
						endcase
					end else begin
						// Printable byte, with wrap at the column limit
						if (b[7]) begin
							style_d[dmp_pkg::F_ITALIC] = 1'b1;
						end
						if (c7 != 7'd0) begin
							cols_d = cols_q + 8'd1;
							ev_d[0] = mk_ev(dmp_pkg::EV_CHAR,
								(c7 < 7'd32 || c7 == 7'h7F) ? 7'd32 : c7, 8'd0, 3'd1, style_d);
							n_d = 2'd1;
						end
						limit = style_d[dmp_pkg::F_COND] ? dmp_pkg::COLS_COND :
							(style_d[dmp_pkg::F_ELITE] ? dmp_pkg::COLS_ELITE : dmp_pkg::COLS_PICA);
						if (cols_d >= limit) begin
							cols_d = 8'd0;
							vy_d = vy_lf;
							ev_d[n_d] = mk_ev(dmp_pkg::EV_FLUSH, 7'd0, 8'd0, 3'd1, style_d);
							n_d = n_d + 2'd1;
							ev_d[n_d] = mk_ev(dmp_pkg::EV_LF, 7'd0, 8'd0, 3'd1, style_d);
							n_d = n_d + 2'd1;
						end
					end
				end
			endcase
		end
	end

	// Remainder step of the page-length division
	always_comb begin
		rem_nx = {rem_q[15:0], dsh_q[CB-1]};
		if (rem_nx >= {1'b0, pdiv}) begin
			rem_nx = rem_nx - {1'b0, pdiv};
		end
		ff_t = ffb_q - (CB+2)'(rem_nx);
	end

	assign last_ev = (idx_q == n_q - 2'd1);

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			dmp_pkg::BK_IDLE: begin
				if (head_valid) begin
					if (ff_d) begin
						st_d = dmp_pkg::BK_DIV;
					end else if (n_d != 2'd0) begin
						st_d = dmp_pkg::BK_EMIT;
					end
				end
			end
			dmp_pkg::BK_DIV: begin
				if (dcnt_q == CW'(CB - 1)) begin
					st_d = dmp_pkg::BK_EMIT;
				end
			end
			dmp_pkg::BK_EMIT: begin
				if (load && last_ev) begin
					st_d = dmp_pkg::BK_IDLE;
				end
			end
			default: st_d = dmp_pkg::BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop  = (st_q == dmp_pkg::BK_IDLE) && head_valid;
		load = (st_q == dmp_pkg::BK_EMIT) && (!out_v_q || out_ch.ready);
	end

	// Parser state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dmp_pkg::BK_IDLE;
			pst_q    <= dmp_pkg::PS_TEXT;
			gmode_q  <= dmp_pkg::GM_Z;
			skip_q   <= 1'b0;
			style_q  <= 7'd0;
			script_q <= 2'd0;
			ls_q     <= dmp_pkg::LS_RESET;
			vy_q     <= CB'(dmp_pkg::TM_RESET);
			cols_q   <= 8'd0;
			grem_q   <= 16'd0;
			n_q      <= 2'd0;
			idx_q    <= 2'd0;
			dcnt_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				pst_q    <= pst_d;
				gmode_q  <= gmode_d;
				skip_q   <= skip_d;
				style_q  <= style_d;
				script_q <= script_d;
				ls_q     <= ls_d;
				vy_q     <= vy_d;
				cols_q   <= cols_d;
				grem_q   <= grem_d;
				n_q      <= n_d;
				idx_q    <= 2'd0;
				dcnt_q   <= '0;
			end
			if (st_q == dmp_pkg::BK_DIV) begin
				dcnt_q <= dcnt_q + CW'(1);
				if (dcnt_q == CW'(CB - 1)) begin
					vy_q <= (ff_t > (CB+2)'(VMAX)) ? VMAX : ff_t[CB-1:0];
				end
			end
			if (load) begin
				idx_q <= idx_q + 2'd1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Event list, divider datapath and old cursor
	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q     <= ev_d;
			vy_old_q <= vy_q;
			rem_q    <= 17'd0;
			dsh_q    <= vy_q;
			ffb_q    <= {2'b00, vy_q} + (CB+2)'(pdiv) + (CB+2)'(top_margin);
		end else if (st_q == dmp_pkg::BK_DIV) begin
			rem_q <= rem_nx;
			dsh_q <= {dsh_q[CB-2:0], 1'b0};
		end
	end

	assign cur    = ev_q[idx_q];
	assign y_sel  = (cur.kind == dmp_pkg::EV_LF || cur.kind == dmp_pkg::EV_FF ||
		cur.kind == dmp_pkg::EV_VF) ? vy_q : vy_old_q;
	assign y_wide = {24'd0, y_sel};

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_ch.event_kind      <= cur.kind;
			out_ch.char_code       <= cur.ch;
			out_ch.pin_bits        <= cur.pins;
			out_ch.dot_width       <= cur.dw;
			out_ch.style_flags     <= cur.style;
			out_ch.cursor_y        <= (y_sel > YMAX) ? 24'hFFFFFF : y_wide[23:0];
			out_ch.script_mode     <= script_q;
			out_ch.line_height_out <= ls_q;
			out_ch.last_event      <= last_ev;
		end
	end

	assign out_ch.valid = out_v_q;

endmodule

[src/dot_matrix_escape_code_parser.sv]
// Escape-code parser for a dot-matrix print stream. Bytes enter through a
// two-entry queue and are decoded one at a time; each byte yields zero to
// three events, delivered one per cycle through an output register while
// the output is not stalled. The events of a byte are held in an event list
// and loaded into the output register in order; the back end takes no new
// byte until the last event of the current byte has been loaded. A form feed
// first runs a bit-serial remainder by page length over the CURSOR_BITS bits
// of the cursor. Configuration writes take effect at once and must be made
// while the parser is idle.
module dot_matrix_escape_code_parser #(
	parameter int CURSOR_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	dmp_in_if.sink      in_ch,
	dmp_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	logic [9:0]      tm_q;
	logic [15:0]     pl_q;
	dmp_pkg::qitem_t head;
	logic            head_valid;
	logic            pop;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tm_q <= dmp_pkg::TM_RESET;
			pl_q <= dmp_pkg::PL_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == dmp_pkg::CFG_TOP_MARGIN) begin
				tm_q <= cfg_data[9:0];
			end else begin
				pl_q <= cfg_data;
			end
		end
	end

	dmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	dmp_back #(
		.CB (CURSOR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.top_margin  (tm_q),
		.page_length (pl_q),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

[src/dmp_checker.sv]
module dmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_kind,
	input logic [6:0]  char_code,
	input logic [7:0]  pin_bits,
	input logic [2:0]  dot_width,
	input logic [23:0] cursor_y
);

	// Hold a stalled item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(cursor_y))
		else $error("stalled output item changed");

	// Drop char code on non-char events
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != dmp_pkg::EV_CHAR |-> char_code == 7'd0)
		else $error("char code on non-char event");

	// Keep pins and width neutral outside graphics
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != dmp_pkg::EV_GFX |-> pin_bits == 8'd0 && dot_width == 3'd1)
		else $error("graphic fields on non-graphic event");

	// Graphic width is one of the legal column widths
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == dmp_pkg::EV_GFX |->
		dot_width == 3'd1 || dot_width == 3'd2 || dot_width == 3'd4)
		else $error("bad graphic width");

endmodule

bind dot_matrix_escape_code_parser dmp_checker u_dmp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.event_kind (out_ch.event_kind),
	.char_code  (out_ch.char_code),
	.pin_bits   (out_ch.pin_bits),
	.dot_width  (out_ch.dot_width),
	.cursor_y   (out_ch.cursor_y)
);
